/* hw/rtl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and controller/datapath command codes for the
// Markov chain stationary distribution block.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Storage sizes and number format
  localparam int TABLE_DEPTH = 1024;
  localparam int DIST_DEPTH  = 256;
  localparam int TBL_AW      = 10;
  localparam int DIST_AW     = 8;
  localparam int PROB_W      = 32;
  localparam int SUM_W       = 37;   // up to 31 weights of 32 bits
  localparam int ACC_W       = 37;   // up to 31 product terms per entry
  localparam logic [PROB_W-1:0] PROB_MAX = '1;

  // Request kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_RDTBL = 2'd2;
  localparam logic [1:0] KIND_RDST  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_NOCONV  = 2'd2;
  localparam logic [1:0] ST_NOTCOMP = 2'd3;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_ALPHABET = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ORDER    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_STAT_EN  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_TOL      = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MAX_IT   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  index;
    logic [31:0] weight;
  } in_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [15:0] iterations;
  } out_rsp_t;

  // Datapath commands, one per cycle
  typedef enum logic [5:0] {
    OP_NOP, OP_CAPTURE, OP_WRITE, OP_SZ_INIT, OP_SZ_STEP, OP_RUN_ERR,
    OP_RD_ERR, OP_RD_ISSUE, OP_RD_DONE, OP_N_FIRST, OP_SUM_START, OP_N_RD,
    OP_SUM_ACC, OP_ROW_NEXT, OP_COL_RESET, OP_DIV_ROW, OP_N_WR,
    OP_RUN_NOSTAT, OP_U_START, OP_FILL, OP_P_CONV, OP_P_FAIL, OP_P_START,
    OP_A_RD, OP_A_MUL, OP_A_WR, OP_F_RD, OP_F_CMP1, OP_F_CMP2,
    OP_RD3_ERR3, OP_RD3_ERR1, OP_RD3_ISSUE, OP_RD3_DONE, OP_OUT_LOAD
  } op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic sz_done;
    logic sz_bad;
    logic rd_idx_bad;
    logic is_run;
    logic rows_done;
    logic col_last;
    logic sum_zero;
    logic div_busy;
    logic stat_en;
    logic pos_last;
    logic conv;
    logic at_limit;
    logic e_last;
    logic computed;
    logic idx3_bad;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/msd_div.sv */
// ----------------------------------------------------------------------------
// msd_div
// Restoring divider, one quotient bit per cycle: floor(w * 2^32 / s),
// saturated to 32 bits if it is below 2^33; higher quotient bits are lost.
// ----------------------------------------------------------------------------
module msd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msd_pkg::PROB_W-1:0]  dividend,
  input  logic [msd_pkg::SUM_W-1:0]   divisor,
  output logic                        busy,
  output logic [msd_pkg::PROB_W-1:0]  quotient
);

  logic [63:0]                  sh_r;
  logic [msd_pkg::SUM_W-1:0]    rem_r;
  logic [msd_pkg::SUM_W-1:0]    dvs_r;
  logic [32:0]                  q_r;
  logic [5:0]                   cnt_r;
  logic                         busy_r;
  logic [msd_pkg::SUM_W:0]      rs;
  logic                         take;

  // trial subtract
  always_comb begin
    rs   = {rem_r, sh_r[63]};
    take = (rs >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      sh_r   <= {dividend, 32'd0};
      rem_r  <= '0;
      dvs_r  <= divisor;
      q_r    <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[62:0], 1'b0};
      rem_r <= take ? msd_pkg::SUM_W'(rs - {1'b0, dvs_r}) : msd_pkg::SUM_W'(rs);
      q_r   <= {q_r[31:0], take};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r[32] ? msd_pkg::PROB_MAX : q_r[31:0];

endmodule

/* hw/rtl/msd_ctrl.sv */
// ----------------------------------------------------------------------------
// msd_ctrl
// Controller: sequences weight writes, sizing, row normalization, power
// iteration and reads, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module msd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  input  msd_pkg::stat_t stat,
  output msd_pkg::op_t   op,
  output logic           in_stall
);

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_SZ_INIT, S_SZ_STEP, S_SZ_CHECK, S_RD_DONE,
    S_N_ROW, S_N_SUM_RD, S_N_SUM_ACC, S_N_CHK, S_N_DRD, S_N_DLOAD, S_N_DIV,
    S_N_DWR, S_U_DIV, S_U_FILL, S_P_CHECK, S_A_RD, S_A_MUL, S_A_WR,
    S_F_RD, S_F_CMP1, S_F_CMP2, S_RD3, S_RD3_DONE, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    op        = msd_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = msd_pkg::OP_CAPTURE;
          unique case (in_kind) inside
            msd_pkg::KIND_WRITE: state_nxt = S_WRITE;
            msd_pkg::KIND_RUN, msd_pkg::KIND_RDTBL: state_nxt = S_SZ_INIT;
            default: state_nxt = S_RD3;
          endcase
        end
      end
      S_WRITE: begin
        op = msd_pkg::OP_WRITE;
        state_nxt = S_DONE;
      end
      S_SZ_INIT: begin
        op = msd_pkg::OP_SZ_INIT;
        state_nxt = S_SZ_STEP;
      end
      S_SZ_STEP: begin
        if (stat.sz_done) state_nxt = S_SZ_CHECK;
        else op = msd_pkg::OP_SZ_STEP;
      end
      S_SZ_CHECK: begin
        if (stat.is_run) begin
          if (stat.sz_bad) begin
            op = msd_pkg::OP_RUN_ERR;
            state_nxt = S_DONE;
          end else begin
            op = msd_pkg::OP_N_FIRST;
            state_nxt = S_N_ROW;
          end
        end else if (stat.sz_bad || stat.rd_idx_bad) begin
          op = msd_pkg::OP_RD_ERR;
          state_nxt = S_DONE;
        end else begin
          op = msd_pkg::OP_RD_ISSUE;
          state_nxt = S_RD_DONE;
        end
      end
      S_RD_DONE: begin
        op = msd_pkg::OP_RD_DONE;
        state_nxt = S_DONE;
      end
      // row normalization
      S_N_ROW: begin
        if (stat.rows_done) begin
          if (stat.stat_en) begin
            op = msd_pkg::OP_U_START;
            state_nxt = S_U_DIV;
          end else begin
            op = msd_pkg::OP_RUN_NOSTAT;
            state_nxt = S_DONE;
          end
        end else begin
          op = msd_pkg::OP_SUM_START;
          state_nxt = S_N_SUM_RD;
        end
      end
      S_N_SUM_RD: begin
        op = msd_pkg::OP_N_RD;
        state_nxt = S_N_SUM_ACC;
      end
      S_N_SUM_ACC: begin
        op = msd_pkg::OP_SUM_ACC;
        state_nxt = stat.col_last ? S_N_CHK : S_N_SUM_RD;
      end
      S_N_CHK: begin
        if (stat.sum_zero) begin
          op = msd_pkg::OP_ROW_NEXT;
          state_nxt = S_N_ROW;
        end else begin
          op = msd_pkg::OP_COL_RESET;
          state_nxt = S_N_DRD;
        end
      end
      S_N_DRD: begin
        op = msd_pkg::OP_N_RD;
        state_nxt = S_N_DLOAD;
      end
      S_N_DLOAD: begin
        op = msd_pkg::OP_DIV_ROW;
        state_nxt = S_N_DIV;
      end
      S_N_DIV: begin
        if (!stat.div_busy) state_nxt = S_N_DWR;
      end
      S_N_DWR: begin
        op = msd_pkg::OP_N_WR;
        state_nxt = stat.col_last ? S_N_ROW : S_N_DRD;
      end
      // uniform start
      S_U_DIV: begin
        if (!stat.div_busy) state_nxt = S_U_FILL;
      end
      S_U_FILL: begin
        op = msd_pkg::OP_FILL;
        if (stat.pos_last) state_nxt = S_P_CHECK;
      end
      // power iteration
      S_P_CHECK: begin
        if (stat.conv) begin
          op = msd_pkg::OP_P_CONV;
          state_nxt = S_DONE;
        end else if (stat.at_limit) begin
          op = msd_pkg::OP_P_FAIL;
          state_nxt = S_DONE;
        end else begin
          op = msd_pkg::OP_P_START;
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        op = msd_pkg::OP_A_RD;
        state_nxt = S_A_MUL;
      end
      S_A_MUL: begin
        op = msd_pkg::OP_A_MUL;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        op = msd_pkg::OP_A_WR;
        state_nxt = stat.e_last ? S_F_RD : S_A_RD;
      end
      S_F_RD: begin
        op = msd_pkg::OP_F_RD;
        state_nxt = S_F_CMP1;
      end
      S_F_CMP1: begin
        op = msd_pkg::OP_F_CMP1;
        state_nxt = S_F_CMP2;
      end
      S_F_CMP2: begin
        op = msd_pkg::OP_F_CMP2;
        state_nxt = stat.pos_last ? S_P_CHECK : S_F_RD;
      end
      // stationary read
      S_RD3: begin
        if (!stat.computed) begin
          op = msd_pkg::OP_RD3_ERR3;
          state_nxt = S_DONE;
        end else if (stat.idx3_bad) begin
          op = msd_pkg::OP_RD3_ERR1;
          state_nxt = S_DONE;
        end else begin
          op = msd_pkg::OP_RD3_ISSUE;
          state_nxt = S_RD3_DONE;
        end
      end
      S_RD3_DONE: begin
        op = msd_pkg::OP_RD3_DONE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          op = msd_pkg::OP_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // no request is taken while in reset
  assign in_stall = (state_r != S_IDLE) || !rst_n;

endmodule

/* hw/rtl/msd_dp.sv */
// ----------------------------------------------------------------------------
// msd_dp
// Datapath: configuration registers, transition table, distribution and
// pass accumulator memories, counters, multipliers, result register.
// ----------------------------------------------------------------------------
module msd_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msd_pkg::op_t                  op,
  input  msd_pkg::in_req_t              in_data,
  input  logic                          cfg_we,
  input  logic [msd_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          out_stall,
  output logic                          out_valid,
  output msd_pkg::out_rsp_t             out_data,
  output msd_pkg::stat_t                stat
);

  // configuration
  logic [4:0]  a_r;
  logic [3:0]  m_r;
  logic        se_r;
  logic [31:0] tol_r;
  logic [15:0] maxit_r;

  // captured request
  logic [1:0]  kind_r;
  logic [9:0]  idx_r;
  logic [31:0] weight_r;

  // sizing
  logic [10:0] n_r;
  logic [10:0] d_r;
  logic [3:0]  cnt_r;
  logic        sz_err_r;
  logic        sz_done_r;
  logic [15:0] sz_prod;

  // sequencing counters
  logic [10:0] base_r;
  logic [8:0]  row_r;
  logic [4:0]  j_r;
  logic [9:0]  e_r;
  logic [7:0]  pos_r;
  logic [msd_pkg::SUM_W-1:0] sum_r;

  // iteration state
  logic        ok_r;
  logic        computed_r;
  logic [15:0] pc_r;
  logic [8:0]  dist_len_r;
  logic [63:0] prod_r;
  logic [31:0] diff_r;
  logic        ov_zero_r;
  logic        nv_nz_r;
  logic [63:0] tolp_r;

  // result and output register
  msd_pkg::out_rsp_t res_r;
  msd_pkg::out_rsp_t out_data_r;
  logic              out_valid_r;

  // memories
  logic [31:0] tbl_mem [msd_pkg::TABLE_DEPTH];
  logic [31:0] dist_mem [msd_pkg::DIST_DEPTH];
  logic [msd_pkg::ACC_W-1:0] acc_mem [msd_pkg::DIST_DEPTH];

  logic                        t_we, t_re;
  logic [msd_pkg::TBL_AW-1:0]  t_waddr, t_raddr;
  logic [31:0]                 t_wdata, t_rdata_r;
  logic                        d_we, d_re;
  logic [msd_pkg::DIST_AW-1:0] d_waddr, d_raddr;
  logic [31:0]                 d_wdata, d_rdata_r;
  logic                        a_we, a_re;
  logic [msd_pkg::ACC_W-1:0]   a_wdata, a_rdata_r;

  // divider
  logic                        div_start, div_busy;
  logic [31:0]                 div_w, div_q;
  logic [msd_pkg::SUM_W-1:0]   div_s;

  // misc combinational
  logic [msd_pkg::TBL_AW-1:0]  tbl_naddr;
  logic                        first_lap;
  logic [31:0]                 nv;
  logic                        col_last, pos_last;

  assign sz_prod   = 16'(n_r) * 16'(a_r);
  assign tbl_naddr = msd_pkg::TBL_AW'(base_r + 11'(j_r));
  assign first_lap = (11'(e_r) < d_r);
  assign col_last  = (j_r == a_r - 5'd1);
  assign pos_last  = (11'(pos_r) == d_r - 11'd1);
  assign nv        = (a_rdata_r > msd_pkg::ACC_W'(msd_pkg::PROB_MAX)) ?
                     msd_pkg::PROB_MAX : a_rdata_r[31:0];

  // memory port selection
  always_comb begin
    t_we = 1'b0; t_waddr = idx_r; t_wdata = weight_r;
    t_re = 1'b0; t_raddr = idx_r;
    d_we = 1'b0; d_waddr = pos_r; d_wdata = div_q;
    d_re = 1'b0; d_raddr = pos_r;
    a_we = 1'b0; a_re = 1'b0;
    a_wdata = (first_lap ? '0 : a_rdata_r) + msd_pkg::ACC_W'(prod_r[63:32]);
    div_start = 1'b0; div_w = t_rdata_r; div_s = sum_r;
    case (op)
      msd_pkg::OP_WRITE:  t_we = 1'b1;
      msd_pkg::OP_RD_ISSUE: t_re = 1'b1;
      msd_pkg::OP_N_RD: begin
        t_re = 1'b1; t_raddr = tbl_naddr;
      end
      msd_pkg::OP_N_WR: begin
        t_we = 1'b1; t_waddr = tbl_naddr; t_wdata = div_q;
      end
      msd_pkg::OP_DIV_ROW: div_start = 1'b1;
      msd_pkg::OP_U_START: begin
        div_start = 1'b1; div_w = 32'd1; div_s = msd_pkg::SUM_W'(d_r);
      end
      msd_pkg::OP_FILL: d_we = 1'b1;
      msd_pkg::OP_A_RD: begin
        t_re = 1'b1; t_raddr = e_r;
        d_re = 1'b1; d_raddr = row_r[7:0];
        a_re = 1'b1;
      end
      msd_pkg::OP_A_WR: a_we = 1'b1;
      msd_pkg::OP_F_RD: begin
        d_re = 1'b1; a_re = 1'b1;
      end
      msd_pkg::OP_F_CMP1: begin
        d_we = 1'b1; d_wdata = nv;
      end
      msd_pkg::OP_RD3_ISSUE: begin
        d_re = 1'b1; d_raddr = idx_r[7:0];
      end
      default: ;
    endcase
  end

  // memory arrays, registered reads
  always_ff @(posedge clk) begin
    if (t_we) tbl_mem[t_waddr] <= t_wdata;
    if (t_re) t_rdata_r <= tbl_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    if (d_re) d_rdata_r <= dist_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) acc_mem[pos_r] <= a_wdata;
    if (a_re) a_rdata_r <= acc_mem[pos_r];
  end

  msd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_w),
    .divisor  (div_s),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= 5'd4;
      m_r     <= 4'd1;
      se_r    <= 1'b1;
      tol_r   <= 32'd1;
      maxit_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msd_pkg::CFG_ALPHABET: a_r     <= cfg_wdata[4:0];
        msd_pkg::CFG_ORDER:    m_r     <= cfg_wdata[3:0];
        msd_pkg::CFG_STAT_EN:  se_r    <= cfg_wdata[0];
        msd_pkg::CFG_TOL:      tol_r   <= cfg_wdata;
        msd_pkg::CFG_MAX_IT:   maxit_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      computed_r  <= 1'b0;
      pc_r        <= '0;
      dist_len_r  <= '0;
      ok_r        <= 1'b0;
      sz_done_r   <= 1'b0;
      sz_err_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result leaves unless a new one is loaded this cycle
      if (out_valid_r && !out_stall && op != msd_pkg::OP_OUT_LOAD) out_valid_r <= 1'b0;
      case (op) inside
        msd_pkg::OP_CAPTURE: begin
          kind_r   <= in_data.kind;
          idx_r    <= in_data.index;
          weight_r <= in_data.weight;
          res_r    <= '0;
        end
        msd_pkg::OP_SZ_INIT: begin
          n_r       <= 11'd1;
          d_r       <= '0;
          cnt_r     <= '0;
          sz_err_r  <= (a_r == 5'd0);
          sz_done_r <= (a_r == 5'd0);
          if (kind_r == msd_pkg::KIND_RUN) begin
            computed_r <= 1'b0;
            pc_r       <= '0;
            ok_r       <= 1'b0;
          end
        end
        msd_pkg::OP_SZ_STEP: begin
          d_r <= n_r;
          if (sz_prod > 16'(msd_pkg::TABLE_DEPTH)) begin
            sz_err_r  <= 1'b1;
            sz_done_r <= 1'b1;
          end else begin
            n_r   <= sz_prod[10:0];
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == m_r) sz_done_r <= 1'b1;
          end
        end
        msd_pkg::OP_RUN_ERR, msd_pkg::OP_RD_ERR, msd_pkg::OP_RD3_ERR1:
          res_r.status <= msd_pkg::ST_RANGE;
        msd_pkg::OP_RD3_ERR3: res_r.status <= msd_pkg::ST_NOTCOMP;
        msd_pkg::OP_RD_DONE:  res_r.value <= t_rdata_r;
        msd_pkg::OP_RD3_DONE: res_r.value <= d_rdata_r;
        msd_pkg::OP_N_FIRST: begin
          base_r <= '0;
          row_r  <= '0;
        end
        msd_pkg::OP_SUM_START: begin
          sum_r <= '0;
          j_r   <= '0;
        end
        msd_pkg::OP_SUM_ACC: begin
          sum_r <= sum_r + msd_pkg::SUM_W'(t_rdata_r);
          j_r   <= j_r + 5'd1;
        end
        msd_pkg::OP_ROW_NEXT: begin
          base_r <= base_r + 11'(a_r);
          row_r  <= row_r + 9'd1;
        end
        msd_pkg::OP_COL_RESET: j_r <= '0;
        msd_pkg::OP_N_WR: begin
          if (col_last) begin
            base_r <= base_r + 11'(a_r);
            row_r  <= row_r + 9'd1;
          end else begin
            j_r <= j_r + 5'd1;
          end
        end
        msd_pkg::OP_U_START: begin
          dist_len_r <= d_r[8:0];
          pos_r      <= '0;
        end
        msd_pkg::OP_FILL: pos_r <= pos_last ? 8'd0 : pos_r + 8'd1;
        msd_pkg::OP_P_CONV: begin
          computed_r       <= 1'b1;
          res_r.iterations <= pc_r;
        end
        msd_pkg::OP_P_FAIL: begin
          res_r.status     <= msd_pkg::ST_NOCONV;
          res_r.iterations <= pc_r;
        end
        msd_pkg::OP_P_START: begin
          pc_r  <= pc_r + 16'd1;
          ok_r  <= 1'b1;
          e_r   <= '0;
          j_r   <= '0;
          row_r <= '0;
          pos_r <= '0;
        end
        msd_pkg::OP_A_MUL: prod_r <= 64'(t_rdata_r) * 64'(d_rdata_r);
        msd_pkg::OP_A_WR: begin
          e_r   <= e_r + 10'd1;
          pos_r <= pos_last ? 8'd0 : pos_r + 8'd1;
          if (col_last) begin
            j_r   <= '0;
            row_r <= row_r + 9'd1;
          end else begin
            j_r <= j_r + 5'd1;
          end
        end
        msd_pkg::OP_F_CMP1: begin
          diff_r    <= (nv >= d_rdata_r) ? nv - d_rdata_r : d_rdata_r - nv;
          ov_zero_r <= (d_rdata_r == 32'd0);
          nv_nz_r   <= (nv != 32'd0);
          tolp_r    <= 64'(tol_r) * 64'(d_rdata_r);
        end
        msd_pkg::OP_F_CMP2: begin
          if (ov_zero_r ? nv_nz_r : ({diff_r, 32'd0} > tolp_r)) ok_r <= 1'b0;
          pos_r <= pos_last ? 8'd0 : pos_r + 8'd1;
        end
        msd_pkg::OP_OUT_LOAD: begin
          out_valid_r <= 1'b1;
          out_data_r  <= res_r;
        end
        default: ;
      endcase
    end
  end

  // status to controller
  always_comb begin
    stat.sz_done    = sz_done_r;
    stat.sz_bad     = sz_err_r || (d_r > 11'(msd_pkg::DIST_DEPTH));
    stat.rd_idx_bad = (11'(idx_r) >= n_r);
    stat.is_run     = (kind_r == msd_pkg::KIND_RUN);
    stat.rows_done  = (11'(row_r) == d_r);
    stat.col_last   = col_last;
    stat.sum_zero   = (sum_r == '0);
    stat.div_busy   = div_busy;
    stat.stat_en    = se_r;
    stat.pos_last   = pos_last;
    stat.conv       = ok_r;
    stat.at_limit   = (pc_r >= maxit_r);
    stat.e_last     = (11'(e_r) == n_r - 11'd1);
    stat.computed   = computed_r;
    stat.idx3_bad   = (idx_r >= 10'(dist_len_r));
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/markov_stationary_distribution.sv */
// ----------------------------------------------------------------------------
// markov_stationary_distribution
// Order-m Markov chain weight store, row normalizer and power-iteration
// stationary distribution solver with single-request handshaked channels.
// ----------------------------------------------------------------------------
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken. A run, like a table read, first
// sizes the table, then normalizes each row: it sums the row and, for a
// nonzero row, divides each entry by the sum in the bit-serial divider.
// With the solver on, the uniform start divides once and fills the
// distribution; each pass multiplies every table entry into the accumulator,
// then updates and compares each distribution entry, all through the single
// read port of each memory. There is no clearing pass.
module markov_stationary_distribution (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  msd_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output msd_pkg::out_rsp_t           out_data,
  input  logic                        cfg_we,
  input  logic [msd_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                 cfg_wdata
);

  msd_pkg::op_t   op;
  msd_pkg::stat_t stat;

  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .op       (op),
    .in_stall (in_stall)
  );

  msd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

/* dv/markov_stationary_distribution_test.sv */
// ----------------------------------------------------------------------------
// markov_stationary_distribution_test
// Self-checking bench for the Markov chain solver: random weight loads, runs
// and reads over many table shapes, checked against an in-bench predictor of
// row normalization and power iteration, with random idling on both channels.
// ----------------------------------------------------------------------------
module markov_stationary_distribution_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  msd_pkg::in_req_t            in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  msd_pkg::out_rsp_t           out_data;
  logic                        cfg_we = 1'b0;
  logic [msd_pkg::CFG_IW-1:0]  cfg_index = '0;
  logic [31:0]                 cfg_wdata = '0;

  markov_stationary_distribution DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers, table and distribution
  // --------------------------------------------------------------------------
  logic [4:0]  shadow_alpha;
  logic [3:0]  shadow_order;
  logic        shadow_stat_en;
  logic [31:0] shadow_tol;
  logic [15:0] shadow_max_it;

  logic [31:0] chain_tbl  [msd_pkg::TABLE_DEPTH];
  logic [31:0] chain_dist [msd_pkg::DIST_DEPTH];
  logic [31:0] chain_prev [msd_pkg::DIST_DEPTH];
  logic [63:0] chain_acc  [msd_pkg::DIST_DEPTH];
  bit          chain_computed;
  int          chain_dist_len;

  msd_pkg::in_req_t  request_q  [$];
  msd_pkg::out_rsp_t response_q [$];
  int          err_count;
  bit          req_taken;
  bit          no_idle;
  int          hold_left;
  bit          written [msd_pkg::TABLE_DEPTH];

  // Table size n = A^(m+1) and context count d = A^m; 0 on a size error
  function automatic bit table_dims(output int n, output int d);
    int i;
    n = 1;
    d = 0;
    if (shadow_alpha == 0) return 0;
    for (i = 0; i <= shadow_order; i++) begin
      n = n * shadow_alpha;
      if (n > msd_pkg::TABLE_DEPTH) return 0;
    end
    d = n / shadow_alpha;
    if (d > msd_pkg::DIST_DEPTH) return 0;
    return 1;
  endfunction

  // Scale each row to sum to one; all-zero rows stay as they are
  function automatic void normalize_rows(int n);
    int base, j;
    logic [63:0] sum, q;
    for (base = 0; base + shadow_alpha <= n; base += shadow_alpha) begin
      sum = 0;
      for (j = 0; j < shadow_alpha; j++) sum += 64'(chain_tbl[base+j]);
      if (sum != 0)
        for (j = 0; j < shadow_alpha; j++) begin
          q = {chain_tbl[base+j], 32'h0} / sum;
          chain_tbl[base+j] = (q > 64'(msd_pkg::PROB_MAX)) ? msd_pkg::PROB_MAX : q[31:0];
        end
    end
  endfunction

  // One power-iteration pass; 1 when every change is within tolerance
  function automatic bit power_pass(int n, int d);
    int e, i, col, row, pos;
    bit ok;
    logic [63:0] p, diff;
    logic [31:0] nv, ov;
    ok = 1;
    col = 0; row = 0; pos = 0;
    for (i = 0; i < msd_pkg::DIST_DEPTH; i++) chain_prev[i] = chain_dist[i];
    for (i = 0; i < d; i++) chain_acc[i] = 0;
    for (e = 0; e < n; e++) begin
      p = 64'(chain_tbl[e]) * 64'(chain_prev[row]);
      chain_acc[pos] += p >> 32;
      pos++;
      if (pos == d) pos = 0;
      col++;
      if (col == shadow_alpha) begin
        col = 0;
        row++;
      end
    end
    for (i = 0; i < d; i++) begin
      nv = (chain_acc[i] > 64'(msd_pkg::PROB_MAX)) ? msd_pkg::PROB_MAX : chain_acc[i][31:0];
      ov = chain_prev[i];
      diff = (nv >= ov) ? 64'(nv - ov) : 64'(ov - nv);
      chain_dist[i] = nv;
      if (ov == 0) begin
        if (nv != 0) ok = 0;
      end else if ((diff << 32) > 64'(shadow_tol) * 64'(ov)) begin
        ok = 0;
      end
    end
    return ok;
  endfunction

  // Expected response for one accepted request; updates the predictor state
  function automatic msd_pkg::out_rsp_t predict_response(msd_pkg::in_req_t r);
    msd_pkg::out_rsp_t o;
    int n, d, i;
    int passes;
    bit ok, dims_ok;
    logic [63:0] start;
    logic [31:0] s;
    o = '0;
    dims_ok = table_dims(n, d);
    case (r.kind)
      msd_pkg::KIND_WRITE: chain_tbl[r.index] = r.weight;
      msd_pkg::KIND_RUN: begin
        chain_computed = 0;
        if (!dims_ok) begin
          o.status = msd_pkg::ST_RANGE;
        end else begin
          normalize_rows(n);
          if (shadow_stat_en) begin
            start = (64'd1 << 32) / d;
            s = (start > 64'(msd_pkg::PROB_MAX)) ? msd_pkg::PROB_MAX : start[31:0];
            for (i = 0; i < d; i++) chain_dist[i] = s;
            chain_dist_len = d;
            ok = 0;
            passes = 0;
            while (!ok && passes < shadow_max_it) begin
              passes++;
              ok = power_pass(n, d);
            end
            o.iterations = passes[15:0];
            if (ok) chain_computed = 1;
            else o.status = msd_pkg::ST_NOCONV;
          end
        end
      end
      msd_pkg::KIND_RDTBL: begin
        if (!dims_ok || r.index >= n) o.status = msd_pkg::ST_RANGE;
        else o.value = chain_tbl[r.index];
      end
      default: begin
        if (!chain_computed) o.status = msd_pkg::ST_NOTCOMP;
        else if (r.index >= chain_dist_len) o.status = msd_pkg::ST_RANGE;
        else o.value = chain_dist[r.index];
      end
    endcase
    return o;
  endfunction

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  int gap_left = 0;
  always @(negedge clk) begin
    logic             v;
    msd_pkg::in_req_t d;
    v = in_valid;
    d = in_data;
    if (!rst_n) begin
      v = 1'b0;
    end else if (!in_valid || req_taken) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0) begin
        d = request_q.pop_front();
        v = 1'b1;
        if (!no_idle && $urandom_range(0, 1) == 0) gap_left = idle_len();
      end
    end
    req_taken = 0;
    in_valid <= v;
    in_data  <= d;
  end

  // Response-side stall, including the long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      st = 1'b1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
    end
    out_stall <= st;
  end

  // Accepted requests: predict; accepted responses: compare
  always @(posedge clk) begin
    msd_pkg::out_rsp_t exp_rsp;
    msd_pkg::out_rsp_t new_rsp;
    if (rst_n && in_valid && !in_stall) begin
      new_rsp = predict_response(in_data);
      response_q = {response_q, new_rsp};
      req_taken = 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (response_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: unexpected response value=%h status=%0d iter=%0d",
                   out_data.value, out_data.status, out_data.iterations);
      end else begin
        exp_rsp = response_q.pop_front();
        if (out_data !== exp_rsp) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: value exp %h got %h, status exp %0d got %0d, iter %0d/%0d",
                     exp_rsp.value, out_data.value, exp_rsp.status, out_data.status,
                     exp_rsp.iterations, out_data.iterations);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [msd_pkg::CFG_IW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      msd_pkg::CFG_ALPHABET: shadow_alpha   = val[4:0];
      msd_pkg::CFG_ORDER:    shadow_order   = val[3:0];
      msd_pkg::CFG_STAT_EN:  shadow_stat_en = val[0];
      msd_pkg::CFG_TOL:      shadow_tol     = val;
      default:               shadow_max_it  = val[15:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || response_q.size() > 0) @(negedge clk);
  endtask

  task automatic push_req(logic [1:0] k, int idx, logic [31:0] w);
    msd_pkg::in_req_t r;
    r.kind = k;
    r.index = idx[9:0];
    r.weight = w;
    if (k == msd_pkg::KIND_WRITE) written[idx] = 1;
    request_q = {request_q, r};
  endtask

  // Configure, then queue a mix of loads, runs and reads
  task automatic run_phase(int a, int m, int se, logic [31:0] tol, int max_it, int count);
    int n, d, k, idx, lim, i, sel;
    bit ok;
    cfg_write(msd_pkg::CFG_ALPHABET, a);
    cfg_write(msd_pkg::CFG_ORDER, m);
    cfg_write(msd_pkg::CFG_STAT_EN, se);
    cfg_write(msd_pkg::CFG_TOL, tol);
    cfg_write(msd_pkg::CFG_MAX_IT, max_it);
    ok = table_dims(n, d);
    lim = ok ? n : 64;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, lim - 1);
        push_req(msd_pkg::KIND_WRITE, idx, rand_weight());
      end else if (sel < 70) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, (lim > 1022) ? 1023 : lim + 1);
        // never read an in-range entry that has not been loaded
        if (!written[idx] && (!ok || idx < n)) push_req(msd_pkg::KIND_WRITE, idx, rand_weight());
        else push_req(msd_pkg::KIND_RDTBL, idx, $urandom);
      end else if (sel < 92) begin
        idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                          : $urandom_range(0, (ok ? d : 4) + 1);
        push_req(msd_pkg::KIND_RDST, idx, $urandom);
      end else begin
        if (ok)
          for (i = 0; i < n; i++)
            if (!written[i]) push_req(msd_pkg::KIND_WRITE, i, rand_weight());
        push_req(msd_pkg::KIND_RUN, $urandom_range(0, 1023), $urandom);
      end
    end
    // always end on a run followed by stationary reads
    if (ok)
      for (i = 0; i < n; i++)
        if (!written[i]) push_req(msd_pkg::KIND_WRITE, i, rand_weight());
    push_req(msd_pkg::KIND_RUN, $urandom_range(0, 1023), $urandom);
    for (i = 0; i < 4; i++)
      push_req(msd_pkg::KIND_RDST, $urandom_range(0, (ok ? d : 4) + 1), $urandom);
    wait_idle();
  endtask

  initial begin
    int ph, a, m, n, d, pick;
    logic [31:0] tol;
    shadow_alpha = 5'd4;
    shadow_order = 4'd1;
    shadow_stat_en = 1'b1;
    shadow_tol = 32'd1;
    shadow_max_it = 16'd1000;
    chain_computed = 0;
    chain_dist_len = 0;
    err_count = 0;
    req_taken = 0;
    no_idle = 0;
    hold_left = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, saturating row, zero row, sparse row, dense row
    push_req(msd_pkg::KIND_RDST, 0, 0);
    push_req(msd_pkg::KIND_WRITE, 0, 32'hFFFF_FFFF);
    push_req(msd_pkg::KIND_WRITE, 1, 32'hFFFF_FFFF);
    push_req(msd_pkg::KIND_WRITE, 2, 0);
    push_req(msd_pkg::KIND_WRITE, 3, 1);
    for (int i = 4; i < 8; i++) push_req(msd_pkg::KIND_WRITE, i, 0);
    push_req(msd_pkg::KIND_WRITE, 8, 1);
    for (int i = 9; i < 12; i++) push_req(msd_pkg::KIND_WRITE, i, 0);
    push_req(msd_pkg::KIND_WRITE, 12, 5);
    push_req(msd_pkg::KIND_WRITE, 13, 6);
    push_req(msd_pkg::KIND_WRITE, 14, 7);
    push_req(msd_pkg::KIND_WRITE, 15, 8);
    push_req(msd_pkg::KIND_RUN, 0, 0);
    push_req(msd_pkg::KIND_RDTBL, 0, 0);
    push_req(msd_pkg::KIND_RDTBL, 15, 0);
    push_req(msd_pkg::KIND_RDTBL, 16, 0);
    push_req(msd_pkg::KIND_RDTBL, 1023, 0);
    push_req(msd_pkg::KIND_RDST, 0, 0);
    push_req(msd_pkg::KIND_RDST, 3, 0);
    push_req(msd_pkg::KIND_RDST, 4, 0);
    wait_idle();

    // Corner settings
    run_phase(0, 1, 1, 32'h100, 10, 30);             // zero alphabet: size error
    run_phase(31, 0, 1, 32'h1000_0000, 20, 40);      // widest alphabet, one context
    run_phase(16, 1, 1, 32'h0100_0000, 6, 40);
    run_phase(4, 4, 1, 32'hFFFF_FFFF, 3, 30);        // full table, full distribution
    run_phase(2, 9, 1, 32'h100, 5, 30);              // contexts overflow
    run_phase(3, 9, 1, 32'h100, 5, 20);              // table overflow
    run_phase(31, 15, 0, 32'h0, 0, 20);
    run_phase(3, 1, 0, 32'h100, 10, 40);             // normalize only
    run_phase(2, 1, 1, 32'h100, 0, 40);              // no passes allowed
    run_phase(1, 0, 1, 32'hFFFF_FFFF, 65535, 30);    // highest pass limit
    run_phase(2, 2, 1, 32'h0, 15, 40);               // exact convergence

    // Receiver holds off while the sender keeps offering
    hold_left = 400;
    run_phase(2, 1, 1, 32'h0800_0000, 10, 60);

    // Random settings, mostly small tables
    for (ph = 0; ph < 34; ph++) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        a = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
      end else begin
        a = $urandom_range(1, 4);
        m = $urandom_range(0, (a > 3) ? 1 : 2);
      end
      case ($urandom_range(0, 3))
        0: tol = 32'h0;
        1: tol = $urandom_range(1, 1 << 20);
        2: tol = $urandom;
        default: tol = 32'hFFFF_FFFF;
      endcase
      shadow_alpha = 5'(a);
      shadow_order = 4'(m);
      // keep the rare large shapes cheap
      if (table_dims(n, d) && n > 64) run_phase(a, m, 1, tol, $urandom_range(1, 3), 30);
      else run_phase(a, m, ($urandom_range(0, 4) != 0), tol, $urandom_range(1, 20), 38);
    end
    no_idle = 0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && response_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/msd_pkg.sv
hw/rtl/msd_div.sv
hw/rtl/msd_ctrl.sv
hw/rtl/msd_dp.sv
hw/rtl/markov_stationary_distribution.sv
dv/markov_stationary_distribution_test.sv
